/* design/hcl_pkg.sv */
// Shared types and constants for the hypergraph component label merge block.
package hcl_pkg;

   localparam int LABEL_W = 7;
   localparam int IDX_W = 6;
   localparam int DEF_NUM_NODES = 64;
   localparam int DEF_NUM_EDGES = 64;

   typedef logic [LABEL_W-1:0] label_type;
   typedef logic [IDX_W-1:0] idx_type;

   typedef enum logic {
      OP_ADD  = 1'b0,
      OP_READ = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_UPDATE,
      ST_RESPOND
   } state_type;

   // Command that walks down a chain of label cells, one cell per cycle.
   typedef struct packed {
      logic      valid;
      logic      update;    // 0: lookup pass, 1: rewrite pass
      idx_type   idx;       // entry that the command addresses
      label_type label;     // lookup result gathered on the way
      logic      fill_en;   // addressed entry takes fill if unlabelled
      label_type fill;
      logic      merge;     // rewrite src_lbl into dst_lbl everywhere
      label_type src_lbl;
      label_type dst_lbl;
   } pkt_type;

endpackage

/* design/hcl_cell.sv */
// One label cell: holds one store entry and hands the command to its neighbor.
module hcl_cell #(
   parameter int IDX = 0,
   parameter int UNLABELLED = hcl_pkg::DEF_NUM_EDGES
) (
   input  logic             clock,
   input  logic             reset,
   input  hcl_pkg::pkt_type pkt_i,
   output hcl_pkg::pkt_type pkt_o
);

   localparam hcl_pkg::idx_type MY_IDX = hcl_pkg::idx_type'(IDX);
   localparam hcl_pkg::label_type UNL_CODE = hcl_pkg::label_type'(UNLABELLED);

   hcl_pkg::label_type label_ff, label_in;
   hcl_pkg::pkt_type   pkt_ff, pkt_in;
   logic               hit;
   hcl_pkg::label_type filled;

   assign hit = pkt_i.valid && (pkt_i.idx == MY_IDX);

   // The addressed entry first takes its fill value if it is still unlabelled,
   // and only then is the merge rewrite applied to it.
   assign filled = (hit && pkt_i.update && pkt_i.fill_en && (label_ff == UNL_CODE))
                   ? pkt_i.fill : label_ff;

   always_comb begin
      label_in = label_ff;
      pkt_in   = pkt_i;
      if (pkt_i.valid && pkt_i.update) begin
         label_in = filled;
         if (pkt_i.merge && (filled == pkt_i.src_lbl)) begin
            label_in = pkt_i.dst_lbl;
         end
      end
      if (hit && !pkt_i.update) begin
         pkt_in.label = label_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         label_ff <= UNL_CODE;
         pkt_ff   <= '0;
      end else begin
         label_ff <= label_in;
         pkt_ff   <= pkt_in;
      end
   end

   assign pkt_o = pkt_ff;

endmodule

/* design/hcl_chain.sv */
// A row of label cells for one store; the command advances one cell per cycle.
module hcl_chain #(
   parameter int DEPTH = hcl_pkg::DEF_NUM_EDGES,
   parameter int UNLABELLED = hcl_pkg::DEF_NUM_EDGES
) (
   input  logic             clock,
   input  logic             reset,
   input  hcl_pkg::pkt_type pkt_i,
   output hcl_pkg::pkt_type pkt_o
);

   hcl_pkg::pkt_type link [DEPTH+1];

   assign link[0] = pkt_i;

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      hcl_cell #(
         .IDX        (k),
         .UNLABELLED (UNLABELLED)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .pkt_i (link[k]),
         .pkt_o (link[k+1])
      );
   end

   assign pkt_o = link[DEPTH];

endmodule

/* design/hypergraph_components_label_merge.sv */
// Top level of the hypergraph connected-components label merge block.
//
//   channel   ports                                            handshake
//   --------  -----------------------------------------------  ---------------------------
//   request   req_opcode, req_node_index, req_edge_index       start high, busy low
//   response  rsp_node_label, rsp_merged                       rsp_valid, one cycle, no stall
//
// An add sends a lookup pass and then a rewrite pass of a command down the cell chains,
// one cell per cycle. A read, or an add whose node or hyperedge index is out of range,
// skips the rewrite pass.
// The block works on one request at a time and holds busy high until the response
// beat has been shown. Synchronous reset sets every label to unlabelled at once.
// The receiver cannot stall: the response beat is on the ports for exactly one cycle.
//
// The node labels and the hyperedge labels each live in a chain of cells, one
// entry per cell. A request first sends a lookup command down both chains in
// parallel, which collects the hyperedge's and the node's current labels. The
// controller then decides the outcome and, for an add, sends a rewrite command
// down both chains: it fills the hyperedge's own number into an unlabelled
// hyperedge, gives an unlabelled node the hyperedge's label, and on a merge
// rewrites every entry that holds the larger label to the smaller one. The
// response value is known as soon as the lookup is done and is held until the
// rewrite pass completes.
module hypergraph_components_label_merge #(
   parameter int NUM_NODES = hcl_pkg::DEF_NUM_NODES,
   parameter int NUM_EDGES = hcl_pkg::DEF_NUM_EDGES
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_opcode,
   input  logic [hcl_pkg::IDX_W-1:0]  req_node_index,
   input  logic [hcl_pkg::IDX_W-1:0]  req_edge_index,
   output logic                       rsp_valid,
   output logic [hcl_pkg::LABEL_W-1:0] rsp_node_label,
   output logic                       rsp_merged
);

   // The unlabelled code is the number of hyperedges, one past the last label.
   localparam hcl_pkg::label_type UNL_CODE = hcl_pkg::label_type'(NUM_EDGES);
   localparam hcl_pkg::label_type NODE_LIM = hcl_pkg::label_type'(NUM_NODES);

   hcl_pkg::state_type state_ff, state_in;

   hcl_pkg::op_type    op_ff;
   hcl_pkg::idx_type   node_ff, edge_ff;
   hcl_pkg::label_type el_ff, nl_ff;
   logic               edone_ff, edone_in;
   logic               ndone_ff, ndone_in;
   hcl_pkg::label_type lbl_ff;
   logic               mrg_ff;

   hcl_pkg::pkt_type   edge_head, node_head;
   hcl_pkg::pkt_type   edge_exit, node_exit;

   logic               accept;
   logic               both_done;
   logic               pass_end;
   logic               go_update;

   // Decision made from the collected labels.
   logic               node_ok;
   logic               add_ok;
   hcl_pkg::label_type el_eff;
   logic               node_fill;
   logic               merge;
   hcl_pkg::label_type lo_lbl, hi_lbl;
   hcl_pkg::label_type result_lbl;

   assign accept    = start && !busy;
   assign both_done = edone_ff && ndone_ff;
   assign pass_end  = both_done &&
                      ((state_ff == hcl_pkg::ST_LOOKUP) || (state_ff == hcl_pkg::ST_UPDATE));
   assign go_update = (state_ff == hcl_pkg::ST_LOOKUP) && both_done && add_ok;

   always_comb begin
      node_ok = hcl_pkg::label_type'(node_ff) < NODE_LIM;
      add_ok  = (op_ff == hcl_pkg::OP_ADD) && node_ok &&
                (hcl_pkg::label_type'(edge_ff) < UNL_CODE);
      // An unlabelled hyperedge counts as carrying its own number.
      el_eff    = (el_ff == UNL_CODE) ? hcl_pkg::label_type'(edge_ff) : el_ff;
      node_fill = (nl_ff == UNL_CODE);
      merge     = add_ok && !node_fill && (nl_ff != el_eff);
      if (nl_ff < el_eff) begin
         lo_lbl = nl_ff;
         hi_lbl = el_eff;
      end else begin
         lo_lbl = el_eff;
         hi_lbl = nl_ff;
      end
      priority if (!node_ok) begin
         result_lbl = UNL_CODE;
      end else if (!add_ok) begin
         result_lbl = nl_ff;
      end else if (node_fill) begin
         result_lbl = el_eff;
      end else if (merge) begin
         result_lbl = lo_lbl;
      end else begin
         result_lbl = nl_ff;
      end
   end

   // Commands injected at the head of each chain.
   always_comb begin
      edge_head = '0;
      node_head = '0;
      if (accept) begin
         edge_head.valid = 1'b1;
         edge_head.idx   = req_edge_index;
         edge_head.label = UNL_CODE;
         node_head.valid = 1'b1;
         node_head.idx   = req_node_index;
         node_head.label = UNL_CODE;
      end else if (go_update) begin
         edge_head.valid   = 1'b1;
         edge_head.update  = 1'b1;
         edge_head.idx     = edge_ff;
         edge_head.fill_en = 1'b1;
         edge_head.fill    = hcl_pkg::label_type'(edge_ff);
         edge_head.merge   = merge;
         edge_head.src_lbl = hi_lbl;
         edge_head.dst_lbl = lo_lbl;
         node_head.valid   = 1'b1;
         node_head.update  = 1'b1;
         node_head.idx     = node_ff;
         node_head.fill_en = node_fill;
         node_head.fill    = el_eff;
         node_head.merge   = merge;
         node_head.src_lbl = hi_lbl;
         node_head.dst_lbl = lo_lbl;
      end
   end

   hcl_chain #(
      .DEPTH      (NUM_EDGES),
      .UNLABELLED (NUM_EDGES)
   ) u_edge_chain (
      .clock (clock),
      .reset (reset),
      .pkt_i (edge_head),
      .pkt_o (edge_exit)
   );

   hcl_chain #(
      .DEPTH      (NUM_NODES),
      .UNLABELLED (NUM_EDGES)
   ) u_node_chain (
      .clock (clock),
      .reset (reset),
      .pkt_i (node_head),
      .pkt_o (node_exit)
   );

   // The shorter chain finishes first; each chain's arrival is remembered
   // until both have delivered.
   always_comb begin
      if (pass_end) begin
         edone_in = 1'b0;
         ndone_in = 1'b0;
      end else begin
         edone_in = edone_ff || edge_exit.valid;
         ndone_in = ndone_ff || node_exit.valid;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hcl_pkg::ST_IDLE: begin
            if (start) begin
               state_in = hcl_pkg::ST_LOOKUP;
            end
         end
         hcl_pkg::ST_LOOKUP: begin
            if (both_done) begin
               state_in = add_ok ? hcl_pkg::ST_UPDATE : hcl_pkg::ST_RESPOND;
            end
         end
         hcl_pkg::ST_UPDATE: begin
            if (both_done) begin
               state_in = hcl_pkg::ST_RESPOND;
            end
         end
         hcl_pkg::ST_RESPOND: begin
            state_in = hcl_pkg::ST_IDLE;
         end
         default: begin
            state_in = hcl_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs of the state machine.
   always_comb begin
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         hcl_pkg::ST_IDLE:    busy = 1'b0;
         hcl_pkg::ST_RESPOND: rsp_valid = 1'b1;
         default: begin
            busy      = 1'b1;
            rsp_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hcl_pkg::ST_IDLE;
         edone_ff <= 1'b0;
         ndone_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         edone_ff <= edone_in;
         ndone_ff <= ndone_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= hcl_pkg::op_type'(req_opcode);
         node_ff <= req_node_index;
         edge_ff <= req_edge_index;
      end
      if (edge_exit.valid && !edge_exit.update) begin
         el_ff <= edge_exit.label;
      end
      if (node_exit.valid && !node_exit.update) begin
         nl_ff <= node_exit.label;
      end
      if ((state_ff == hcl_pkg::ST_LOOKUP) && both_done) begin
         lbl_ff <= result_lbl;
         mrg_ff <= merge;
      end
   end

   assign rsp_node_label = lbl_ff;
   assign rsp_merged     = mrg_ff;

endmodule

/* tb/hcl_tb_pkg.sv */
`timescale 1ns / 1ps
// Label predictor and response scoreboard for the hypergraph label merge testbench.
package hcl_tb_pkg;
   import hcl_pkg::*;

   localparam int NODES = DEF_NUM_NODES;
   localparam int EDGES = DEF_NUM_EDGES;
   localparam label_type NO_LABEL = label_type'(EDGES);

   typedef struct packed {
      label_type node_label;
      logic      merged;
   } label_result_type;

   class label_scoreboard;
      label_type        node_lbl[NODES];
      label_type        edge_lbl[EDGES];
      label_result_type expected_q[$];
      int               errors;
      int               checked;
      int               adds;
      int               reads;
      int               merges;

      function new();
         errors  = 0;
         checked = 0;
         adds    = 0;
         reads   = 0;
         merges  = 0;
         foreach (node_lbl[i]) node_lbl[i] = NO_LABEL;
         foreach (edge_lbl[i]) edge_lbl[i] = NO_LABEL;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Every entry of either store that holds from_lbl now holds to_lbl.
      function void rewrite_label(label_type from_lbl, label_type to_lbl);
         foreach (node_lbl[i]) if (node_lbl[i] == from_lbl) node_lbl[i] = to_lbl;
         foreach (edge_lbl[i]) if (edge_lbl[i] == from_lbl) edge_lbl[i] = to_lbl;
      endfunction

      // Updates the label stores for one accepted request beat and queues its response.
      function void note_request(op_type op, idx_type n, idx_type e);
         label_result_type res;
         label_type        el;
         label_type        nl;
         res.node_label = NO_LABEL;
         res.merged     = 1'b0;
         if (op == OP_ADD) adds++;
         else reads++;
         if (int'(n) < NODES) begin
            if (op == OP_ADD && int'(e) < EDGES) begin
               if (edge_lbl[e] == NO_LABEL) edge_lbl[e] = label_type'(e);
               el = edge_lbl[e];
               nl = node_lbl[n];
               if (el != nl) begin
                  if (nl == NO_LABEL) begin
                     node_lbl[n] = el;
                  end else if (nl > el) begin
                     rewrite_label(nl, el);
                     res.merged = 1'b1;
                  end else begin
                     rewrite_label(el, nl);
                     res.merged = 1'b1;
                  end
               end
            end
            res.node_label = node_lbl[n];
         end
         if (res.merged) merges++;
         expected_q = {expected_q, res};
      endfunction

      function void check_response(label_type lbl, logic mrg);
         label_result_type want;
         if (expected_q.size() == 0) begin
            errors++;
            $display({"%0t: response beat with nothing outstanding: expected none, ",
                      "actual label=%0d merged=%0b"}, $time, lbl, mrg);
         end else begin
            want = expected_q.pop_front();
            checked++;
            if (lbl !== want.node_label) begin
               errors++;
               $display("%0t: node_label mismatch: expected %0d, actual %0d",
                        $time, want.node_label, lbl);
            end
            if (mrg !== want.merged) begin
               errors++;
               $display("%0t: merged mismatch: expected %0b, actual %0b",
                        $time, want.merged, mrg);
            end
         end
      endfunction
   endclass

endpackage

/* tb/tb_hypergraph_components_label_merge.sv */
`timescale 1ns / 1ps
// Top-level testbench for the hypergraph component label merge block.
module tb_hypergraph_components_label_merge;
   import hcl_pkg::*;
   import hcl_tb_pkg::*;

   // Number of random request beats after the directed opening.
   localparam int RANDOM_BEATS = 1700;
   // The drain at the end allows a margin on top of the longest request.
   localparam int DRAIN_CYCLES = 160;

   logic            clock;
   logic            reset;
   logic            start;
   logic            busy;
   logic            req_opcode;
   idx_type         req_node_index;
   idx_type         req_edge_index;
   logic            rsp_valid;
   label_type       rsp_node_label;
   logic            rsp_merged;

   label_scoreboard sb = new();

   hypergraph_components_label_merge i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_node_index (req_node_index),
      .req_edge_index (req_edge_index),
      .rsp_valid      (rsp_valid),
      .rsp_node_label (rsp_node_label),
      .rsp_merged     (rsp_merged)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // The slowest correct run is well under 3 ms; this bound is several times that.
   initial begin
      #12_000_000;
      $display("FAIL hypergraph_components_label_merge");
      $finish;
   end

   // The receiver cannot stall, so every cycle with rsp_valid high is one response beat.
   // Outputs are sampled at the rising edge, before the block's own updates land.
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_response(rsp_node_label, rsp_merged);
   end

   // Waits until the block is idle, then presents one request beat after a random
   // gap whose length is drawn from 0 to max_gap. Inputs change only at falling edges. When the gap
   // is zero, start simply stays high from the previous beat and only the fields
   // change. The beat counts as accepted at the first rising edge at which busy is
   // low; the prediction is made at that point.
   task automatic send_beat(op_type op, idx_type n, idx_type e, int max_gap = 4);
      int gap;
      gap = $urandom_range(0, max_gap);
      @(negedge clock);
      while (busy) @(negedge clock);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start          = 1'b1;
      req_opcode     = op;
      req_node_index = n;
      req_edge_index = e;
      do @(posedge clock); while (busy);
      sb.note_request(op, n, e);
   endtask

   // Drops start and holds off until every outstanding response beat has arrived.
   task automatic drain_responses();
      @(negedge clock);
      start = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   initial begin
      int      span;
      int      max_gap;
      idx_type node;
      start          = 1'b0;
      req_opcode     = OP_ADD;
      req_node_index = '0;
      req_edge_index = '0;
      reset          = 1'b1;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Directed opening. Reads of nodes that were never touched come back unlabelled,
      // and a read ignores its hyperedge field.
      send_beat(OP_READ, 6'd0, 6'd63);
      send_beat(OP_READ, 6'd63, 6'd0);
      // First label of a node: hyperedge 0 takes its own number and node 0 copies it.
      send_beat(OP_ADD, 6'd0, 6'd0);
      // The same pair again has equal labels and changes nothing.
      send_beat(OP_ADD, 6'd0, 6'd0);
      send_beat(OP_ADD, 6'd63, 6'd63);
      send_beat(OP_ADD, 6'd1, 6'd63);
      // Node 1 holds 63 and hyperedge 0 holds 0: the node's larger label gives way.
      send_beat(OP_ADD, 6'd1, 6'd0);
      send_beat(OP_READ, 6'd63, 6'd21);
      send_beat(OP_ADD, 6'd10, 6'd20);
      send_beat(OP_ADD, 6'd11, 6'd30);
      send_beat(OP_ADD, 6'd11, 6'd20);
      send_beat(OP_ADD, 6'd12, 6'd40);
      // Here the hyperedge's own new label is the larger one and is rewritten.
      send_beat(OP_ADD, 6'd12, 6'd50);
      // Merge of two components that each already span several entries.
      send_beat(OP_ADD, 6'd10, 6'd40);
      send_beat(OP_READ, 6'd12, 6'd0);
      // A new node joins a hyperedge whose label is not its own number.
      send_beat(OP_ADD, 6'd20, 6'd50);
      send_beat(OP_ADD, 6'd42, 6'd21);
      send_beat(OP_ADD, 6'd21, 6'd42);
      send_beat(OP_ADD, 6'd42, 6'd42);
      send_beat(OP_READ, 6'd21, 6'd42);
      send_beat(OP_ADD, 6'd63, 6'd20);
      send_beat(OP_READ, 6'd12, 6'd63);

      // Random part. Reset can only happen once, so the stores would collapse into a
      // single component almost at once under uniform pairs. Instead most adds tie a
      // node to a hyperedge a short distance above its own number, and that distance
      // widens over the run: small components form first and then merge step by step.
      // A few fully random adds act as noise, and about a third of the beats are reads.
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         span    = (i * EDGES) / RANDOM_BEATS;
         max_gap = ((i / 100) % 3 == 2) ? 0 : 4;
         node    = idx_type'($urandom_range(0, NODES - 1));
         if ($urandom_range(0, 99) < 30) begin
            send_beat(OP_READ, node, idx_type'($urandom), max_gap);
         end else if ($urandom_range(0, 99) < 5) begin
            send_beat(OP_ADD, node, idx_type'($urandom), max_gap);
         end else begin
            send_beat(OP_ADD, node,
                      idx_type'((int'(node) + $urandom_range(0, span)) % EDGES), max_gap);
         end
         // Halfway through, the sender goes quiet until the block has answered everything.
         if (i == RANDOM_BEATS / 2) drain_responses();
      end

      drain_responses();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Checked %0d response beats for %0d adds and %0d reads;",
               sb.checked, sb.adds, sb.reads);
      $display("%0d adds merged components.", sb.merges);
      if (sb.errors == 0) begin
         $display("PASS hypergraph_components_label_merge");
      end else begin
         $display("FAIL hypergraph_components_label_merge");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/hcl_pkg.sv
design/hcl_cell.sv
design/hcl_chain.sv
design/hypergraph_components_label_merge.sv
tb/hcl_tb_pkg.sv
tb/tb_hypergraph_components_label_merge.sv
